// ===== src/c3d_pkg.sv =====
// Package for the zero-padded 3D convolution unit.
// Holds sizes, register indexes, the mode codes and the command word type.
// Used by every module of the block except c3d_ram.
package c3d_pkg;

  localparam int unsigned MaxDepthDef  = 16;
  localparam int unsigned MaxHeightDef = 64;
  localparam int unsigned MaxWidthDef  = 64;
  localparam int unsigned MaxKernelDef = 7;
  localparam int unsigned SampleBitsDef = 16;

  // Fixed port widths.
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PosDW  = 4;
  localparam int unsigned PosHW  = 6;
  localparam int unsigned PosWW  = 6;
  localparam int unsigned InSampleW = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned KerW   = 3;

  // Mode codes. The last code is ignored by the block.
  localparam logic [ModeW-1:0] ModeImage  = 2'd0;
  localparam logic [ModeW-1:0] ModeKernel = 2'd1;
  localparam logic [ModeW-1:0] ModeRow    = 2'd2;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegInDepth   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInWidth   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKerDepth  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKerHeight = 3'd4;
  localparam logic [CfgIdxW-1:0] RegKerWidth  = 3'd5;

  // Row command passed from the front to the back.
  typedef struct packed {
    logic             bad;
    logic [PosDW-1:0] pos_d;
    logic [PosHW-1:0] pos_h;
  } row_cmd_t;

  // Clamped sizes used by the back end.
  typedef struct packed {
    logic [6:0] dd;
    logic [8:0] hh;
    logic [6:0] ww;
    logic [KerW:0] kd;
    logic [KerW:0] kh;
    logic [KerW:0] kw;
  } sizes_t;

endpackage

// ===== src/conv3d_zero_padded_unit.sv =====
// Top level of the zero-padded 3D convolution unit.
// Depends on c3d_pkg, c3d_front, c3d_cmd_fifo and c3d_back.
//
//   channel   handshake           payload
//   input     push / full         mode, pos_d, pos_h, pos_w, sample
//   result    pop / empty         out_value, out_col, is_last, bad_request
//   config    cfg_valid/cfg_ready cfg_index_i, cfg_data_i
//
// A row request is worked column by column by the single shared multiply-accumulate
// unit, which walks every tap and drains its pipeline for each column.
// Reset clears control state and restores the register defaults; stores keep
// no reset value. The input side stalls when the two-entry row queue is full, and
// loads also wait while a row is queued or in progress, so that every row sees the
// stores as they were when it was requested. Results wait in a one-word register.
module conv3d_zero_padded_unit import c3d_pkg::*; #(
  parameter int unsigned MaxDepth   = MaxDepthDef,
  parameter int unsigned MaxHeight  = MaxHeightDef,
  parameter int unsigned MaxWidth   = MaxWidthDef,
  parameter int unsigned MaxKernel  = MaxKernelDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic [ModeW-1:0]            mode_i,
  input  logic [PosDW-1:0]            pos_d_i,
  input  logic [PosHW-1:0]            pos_h_i,
  input  logic [PosWW-1:0]            pos_w_i,
  input  logic signed [InSampleW-1:0] sample_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [ValueW-1:0]    out_value_o,
  output logic [PosWW-1:0]            out_col_o,
  output logic                        is_last_o,
  output logic                        bad_request_o
);

  localparam int unsigned ImgDepth = MaxDepth * MaxHeight * MaxWidth;
  localparam int unsigned KerDepth = MaxKernel * MaxKernel * MaxKernel;

  logic accept, cmd_push, cmd_pop, cmd_empty, cmd_full, back_busy, row_busy;
  row_cmd_t cmd_in, cmd_out;
  sizes_t sizes;
  logic [$clog2(ImgDepth)-1:0] img_raddr;
  logic [$clog2(KerDepth)-1:0] ker_raddr;
  logic [SampleBits-1:0] img_rdata, ker_rdata;
  logic [ValueW-1:0] value;

  // Row requests only need queue space; any other word waits until no row is pending.
  assign row_busy = !cmd_empty || back_busy;
  assign full = cmd_full || (row_busy && (mode_i != ModeRow));
  assign accept = push && !full;
  assign out_value_o = signed'(value);

  c3d_front #(.MaxDepth(MaxDepth), .MaxHeight(MaxHeight), .MaxWidth(MaxWidth),
              .MaxKernel(MaxKernel), .SampleBits(SampleBits)) u_front (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .accept_i(accept), .mode_i, .pos_d_i, .pos_h_i, .pos_w_i, .sample_i,
    .cmd_push_o(cmd_push), .cmd_o(cmd_in), .sizes_o(sizes),
    .img_raddr_i(img_raddr), .img_rdata_o(img_rdata),
    .ker_raddr_i(ker_raddr), .ker_rdata_o(ker_rdata));

  c3d_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(cmd_push), .data_i(cmd_in), .full_o(cmd_full),
    .pop_i(cmd_pop), .empty_o(cmd_empty), .data_o(cmd_out));

  c3d_back #(.MaxDepth(MaxDepth), .MaxHeight(MaxHeight), .MaxWidth(MaxWidth),
             .MaxKernel(MaxKernel), .SampleBits(SampleBits)) u_back (
    .clk_i, .rst_ni, .cmd_empty_i(cmd_empty), .cmd_i(cmd_out), .cmd_pop_o(cmd_pop),
    .busy_o(back_busy),
    .sizes_i(sizes), .img_raddr_o(img_raddr), .img_rdata_i(img_rdata),
    .ker_raddr_o(ker_raddr), .ker_rdata_i(ker_rdata),
    .empty, .pop, .out_value_o(value), .out_col_o, .is_last_o, .bad_request_o);

  // A bad request word is always flagged last with a zero sum.
  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_request_o) |-> (is_last_o && value == '0))
    else $error("bad request word not last or nonzero");

  // The row queue never pops while empty.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("row queue popped while empty");

  // A waiting word holds while not taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(value) && $stable(out_col_o)))
    else $error("result changed while waiting");

endmodule

// ===== src/c3d_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module c3d_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/c3d_cmd_fifo.sv =====
// Two-entry queue of row commands between the front and the back end.
// Depends on c3d_pkg.
module c3d_cmd_fifo import c3d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  row_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output row_cmd_t data_o
);

  row_cmd_t  slot_q [2];
  logic      wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rptr_q];

  // Pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= data_i;
  end

endmodule

// ===== src/c3d_front.sv =====
// Front end: holds the configuration, classifies items, writes the stores.
// Depends on c3d_pkg and c3d_ram.
module c3d_front import c3d_pkg::*; #(
  parameter int unsigned MaxDepth   = MaxDepthDef,
  parameter int unsigned MaxHeight  = MaxHeightDef,
  parameter int unsigned MaxWidth   = MaxWidthDef,
  parameter int unsigned MaxKernel  = MaxKernelDef,
  parameter int unsigned SampleBits = SampleBitsDef,
  localparam int unsigned ImgDepth = MaxDepth * MaxHeight * MaxWidth,
  localparam int unsigned KerDepth = MaxKernel * MaxKernel * MaxKernel,
  localparam int unsigned ImgAw = $clog2(ImgDepth),
  localparam int unsigned KerAw = $clog2(KerDepth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        accept_i,
  input  logic [ModeW-1:0]            mode_i,
  input  logic [PosDW-1:0]            pos_d_i,
  input  logic [PosHW-1:0]            pos_h_i,
  input  logic [PosWW-1:0]            pos_w_i,
  input  logic signed [InSampleW-1:0] sample_i,
  output logic                        cmd_push_o,
  output row_cmd_t                    cmd_o,
  output sizes_t                      sizes_o,
  input  logic [ImgAw-1:0]            img_raddr_i,
  output logic [SampleBits-1:0]       img_rdata_o,
  input  logic [KerAw-1:0]            ker_raddr_i,
  output logic [SampleBits-1:0]       ker_rdata_o
);

  logic [4:0] in_depth_q;
  logic [6:0] in_height_q, in_width_q;
  logic [KerW-1:0] ker_depth_q, ker_height_q, ker_width_q;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_depth_q   <= 5'd16;
      in_height_q  <= 7'd64;
      in_width_q   <= 7'd64;
      ker_depth_q  <= 3'd3;
      ker_height_q <= 3'd3;
      ker_width_q  <= 3'd3;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        RegInDepth:   in_depth_q   <= cfg_data_i[4:0];
        RegInHeight:  in_height_q  <= cfg_data_i;
        RegInWidth:   in_width_q   <= cfg_data_i;
        RegKerDepth:  ker_depth_q  <= cfg_data_i[KerW-1:0];
        RegKerHeight: ker_height_q <= cfg_data_i[KerW-1:0];
        RegKerWidth:  ker_width_q  <= cfg_data_i[KerW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to the store dimensions.
  always_comb begin
    sizes_o.dd = (32'(in_depth_q) > MaxDepth) ? 7'(MaxDepth) : 7'(in_depth_q);
    sizes_o.hh = (32'(in_height_q) > MaxHeight) ? 9'(MaxHeight) : 9'(in_height_q);
    sizes_o.ww = (32'(in_width_q) > MaxWidth) ? 7'(MaxWidth) : 7'(in_width_q);
    sizes_o.kd = (32'(ker_depth_q) > MaxKernel) ? 4'(MaxKernel) : 4'(ker_depth_q);
    sizes_o.kh = (32'(ker_height_q) > MaxKernel) ? 4'(MaxKernel) : 4'(ker_height_q);
    sizes_o.kw = (32'(ker_width_q) > MaxKernel) ? 4'(MaxKernel) : 4'(ker_width_q);
  end

  // Classify the accepted word.
  logic img_in, ker_in, img_we, ker_we;
  assign img_in = (10'(pos_d_i) < 10'(sizes_o.dd)) && (10'(pos_h_i) < 10'(sizes_o.hh))
                  && (10'(pos_w_i) < 10'(sizes_o.ww));
  assign ker_in = (5'(pos_d_i) < 5'(sizes_o.kd)) && (7'(pos_h_i) < 7'(sizes_o.kh))
                  && (7'(pos_w_i) < 7'(sizes_o.kw));
  assign img_we = accept_i && (mode_i == ModeImage) && img_in;
  assign ker_we = accept_i && (mode_i == ModeKernel) && ker_in;
  assign cmd_push_o = accept_i && (mode_i == ModeRow);
  assign cmd_o.bad = (10'(pos_d_i) >= 10'(sizes_o.dd)) || (10'(pos_h_i) >= 10'(sizes_o.hh))
                     || (sizes_o.ww == 7'd0);
  assign cmd_o.pos_d = pos_d_i;
  assign cmd_o.pos_h = pos_h_i;

  // Store addresses are linear in absolute position.
  logic [ImgAw-1:0] img_waddr;
  logic [KerAw-1:0] ker_waddr;
  assign img_waddr = ImgAw'((32'(pos_d_i) * MaxHeight + 32'(pos_h_i)) * MaxWidth
                     + 32'(pos_w_i));
  assign ker_waddr = KerAw'((32'(pos_d_i) * MaxKernel + 32'(pos_h_i)) * MaxKernel
                     + 32'(pos_w_i));

  logic [SampleBits-1:0] wval;
  assign wval = SampleBits'(32'(sample_i));

  c3d_ram #(.Width(SampleBits), .Depth(ImgDepth)) u_img (
    .clk_i, .we_i(img_we), .waddr_i(img_waddr), .wdata_i(wval),
    .raddr_i(img_raddr_i), .rdata_o(img_rdata_o));

  c3d_ram #(.Width(SampleBits), .Depth(KerDepth)) u_ker (
    .clk_i, .we_i(ker_we), .waddr_i(ker_waddr), .wdata_i(wval),
    .raddr_i(ker_raddr_i), .rdata_o(ker_rdata_o));

endmodule

// ===== src/c3d_back.sv =====
// Back end: walks columns and kernel taps with one shared MAC, registers results.
// Depends on c3d_pkg.
module c3d_back import c3d_pkg::*; #(
  parameter int unsigned MaxDepth   = MaxDepthDef,
  parameter int unsigned MaxHeight  = MaxHeightDef,
  parameter int unsigned MaxWidth   = MaxWidthDef,
  parameter int unsigned MaxKernel  = MaxKernelDef,
  parameter int unsigned SampleBits = SampleBitsDef,
  localparam int unsigned ImgDepth = MaxDepth * MaxHeight * MaxWidth,
  localparam int unsigned KerDepth = MaxKernel * MaxKernel * MaxKernel,
  localparam int unsigned ImgAw = $clog2(ImgDepth),
  localparam int unsigned KerAw = $clog2(KerDepth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_empty_i,
  input  row_cmd_t                    cmd_i,
  output logic                        cmd_pop_o,
  output logic                        busy_o,
  input  sizes_t                      sizes_i,
  output logic [ImgAw-1:0]            img_raddr_o,
  input  logic [SampleBits-1:0]       img_rdata_i,
  output logic [KerAw-1:0]            ker_raddr_o,
  input  logic [SampleBits-1:0]       ker_rdata_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [ValueW-1:0]           out_value_o,
  output logic [PosWW-1:0]            out_col_o,
  output logic                        is_last_o,
  output logic                        bad_request_o
);

  typedef enum logic [1:0] {StIdle, StRun, StDrain, StEmit} state_e;

  state_e state_q;
  logic signed [7:0] col_q, x_q, y_q, z_q;
  logic [PosDW-1:0] pd_q;
  logic [PosHW-1:0] ph_q;
  logic [ValueW-1:0] sum_q;
  logic v1_q, v2_q;           // tap issued, delayed along the read pipeline
  logic inb1_q, inb2_q;       // tap lies inside the volume
  logic signed [SampleBits-1:0] a_q, b_q;
  logic mv_q;
  logic [ValueW-1:0] prod_q;

  // Output register, one word deep.
  logic ov_q;
  assign empty = !ov_q;

  // A row is being worked on while the sequencer is away from idle.
  assign busy_o = (state_q != StIdle);

  // Current tap coordinates.
  logic signed [9:0] d_s, h_s, w_s, padd, padh, padw;
  logic tap_in;
  assign padd = (sizes_i.kd == 4'd0) ? 10'sd0 : 10'((sizes_i.kd - 4'd1) >> 1);
  assign padh = (sizes_i.kh == 4'd0) ? 10'sd0 : 10'((sizes_i.kh - 4'd1) >> 1);
  assign padw = (sizes_i.kw == 4'd0) ? 10'sd0 : 10'((sizes_i.kw - 4'd1) >> 1);
  assign d_s = 10'(signed'({1'b0, pd_q})) + 10'(x_q) - padd;
  assign h_s = 10'(signed'({1'b0, ph_q})) + 10'(y_q) - padh;
  assign w_s = 10'(col_q) + 10'(z_q) - padw;
  assign tap_in = (d_s >= 0) && (d_s < signed'(10'(sizes_i.dd)))
               && (h_s >= 0) && (h_s < signed'(10'(sizes_i.hh)))
               && (w_s >= 0) && (w_s < signed'(10'(sizes_i.ww)));

  assign img_raddr_o = ImgAw'((32'(d_s) * MaxHeight + 32'(h_s)) * MaxWidth + 32'(w_s));
  assign ker_raddr_o = KerAw'((32'(x_q) * MaxKernel + 32'(y_q)) * MaxKernel
                       + 32'(z_q));

  logic kempty;
  assign kempty = (sizes_i.kd == 4'd0) || (sizes_i.kh == 4'd0) || (sizes_i.kw == 4'd0);
  logic last_tap;
  assign last_tap = kempty || ((x_q == 8'(sizes_i.kd) - 8'sd1) && (y_q == 8'(sizes_i.kh) - 8'sd1)
                    && (z_q == 8'(sizes_i.kw) - 8'sd1));

  assign cmd_pop_o = (state_q == StIdle) && !cmd_empty_i && cmd_i.bad && (!ov_q || pop)
                  || (state_q == StIdle) && !cmd_empty_i && !cmd_i.bad;

  // Sequencer, MAC pipeline and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
      v1_q <= 1'b0; v2_q <= 1'b0; mv_q <= 1'b0;
      col_q <= '0; x_q <= '0; y_q <= '0; z_q <= '0;
      inb1_q <= 1'b0; inb2_q <= 1'b0;
      pd_q <= '0; ph_q <= '0; sum_q <= '0;
      a_q <= '0; b_q <= '0; prod_q <= '0;
      out_value_o <= '0; out_col_o <= '0; is_last_o <= 1'b0; bad_request_o <= 1'b0;
    end else begin
      if (pop && ov_q) ov_q <= 1'b0;
      // RAM read data is registered, then held in a_q/b_q; multiply, then add.
      v2_q <= v1_q; inb2_q <= inb1_q;
      v1_q <= 1'b0;
      a_q <= signed'(img_rdata_i);
      b_q <= signed'(ker_rdata_i);
      mv_q <= v2_q && inb2_q;
      prod_q <= ValueW'(32'(a_q) * 32'(b_q));
      if (mv_q) sum_q <= sum_q + prod_q;
      case (state_q)
        StIdle: begin
          if (!cmd_empty_i) begin
            if (cmd_i.bad) begin
              if (!ov_q || pop) begin
                ov_q <= 1'b1;
                out_value_o <= '0; out_col_o <= '0;
                is_last_o <= 1'b1; bad_request_o <= 1'b1;
              end
            end else begin
              pd_q <= cmd_i.pos_d; ph_q <= cmd_i.pos_h;
              col_q <= '0; x_q <= '0; y_q <= '0; z_q <= '0;
              sum_q <= '0;
              state_q <= StRun;
            end
          end
        end
        StRun: begin
          v1_q <= !kempty;
          inb1_q <= tap_in;
          if (last_tap) begin
            state_q <= StDrain;
          end else if (z_q == 8'(sizes_i.kw) - 8'sd1) begin
            z_q <= '0;
            if (y_q == 8'(sizes_i.kh) - 8'sd1) begin
              y_q <= '0; x_q <= x_q + 8'sd1;
            end else begin
              y_q <= y_q + 8'sd1;
            end
          end else begin
            z_q <= z_q + 8'sd1;
          end
        end
        StDrain: begin
          if (!v1_q && !v2_q && !mv_q) state_q <= StEmit;
        end
        StEmit: begin
          if (!ov_q || pop) begin
            ov_q <= 1'b1;
            out_value_o <= sum_q;
            out_col_o <= PosWW'(col_q);
            is_last_o <= (col_q == 8'(sizes_i.ww) - 8'sd1);
            bad_request_o <= 1'b0;
            sum_q <= '0;
            x_q <= '0; y_q <= '0; z_q <= '0;
            if (col_q == 8'(sizes_i.ww) - 8'sd1) begin
              state_q <= StIdle;
            end else begin
              col_q <= col_q + 8'sd1;
              state_q <= StRun;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== verif/c3d_checker.sv =====
// Checker for the zero-padded 3D convolution unit.
// It watches the config, input and result channels, predicts every result and compares.
// Depends on c3d_pkg.
module c3d_checker import c3d_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        push,
  input  logic                        full,
  input  logic [ModeW-1:0]            mode_i,
  input  logic [PosDW-1:0]            pos_d_i,
  input  logic [PosHW-1:0]            pos_h_i,
  input  logic [PosWW-1:0]            pos_w_i,
  input  logic signed [InSampleW-1:0] sample_i,
  input  logic                        empty,
  input  logic                        pop,
  input  logic signed [ValueW-1:0]    out_value_i,
  input  logic [PosWW-1:0]            out_col_i,
  input  logic                        is_last_i,
  input  logic                        bad_request_i,
  output int                          fail_cnt_o,
  output int                          pending_o
);

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic [PosWW-1:0]         col;
    logic                     last;
    logic                     bad;
  } conv_word_t;

  localparam int unsigned VoxWords = MaxDepthDef * MaxHeightDef * MaxWidthDef;
  localparam int unsigned KerWords = MaxKernelDef * MaxKernelDef * MaxKernelDef;

  conv_word_t               conv_sums_q[$];
  logic signed [15:0]       voxel_mem [VoxWords];
  logic signed [15:0]       weight_mem [KerWords];
  int unsigned              in_d, in_h, in_w, k_d, k_h, k_w;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  // Work out every column sum of one requested row, or the single error word.
  task automatic predict_row(input int unsigned pd, input int unsigned ph);
    int unsigned dd, hh, ww, kd, kh, kw;
    int          pad_d, pad_h, pad_w, d, h, w;
    conv_word_t  word;
    logic signed [ValueW-1:0] sum;
    dd = clamp_dim(in_d, MaxDepthDef);
    hh = clamp_dim(in_h, MaxHeightDef);
    ww = clamp_dim(in_w, MaxWidthDef);
    kd = clamp_dim(k_d, MaxKernelDef);
    kh = clamp_dim(k_h, MaxKernelDef);
    kw = clamp_dim(k_w, MaxKernelDef);
    if (pd >= dd || ph >= hh || ww == 0) begin
      word = '{value: '0, col: '0, last: 1'b1, bad: 1'b1};
      conv_sums_q.push_back(word);
      return;
    end
    pad_d = (kd > 0) ? (kd - 1) / 2 : 0;
    pad_h = (kh > 0) ? (kh - 1) / 2 : 0;
    pad_w = (kw > 0) ? (kw - 1) / 2 : 0;
    for (int unsigned col = 0; col < ww; col++) begin
      sum = '0;
      for (int x = 0; x < kd; x++) begin
        d = pd + x - pad_d;
        if (d < 0 || d >= dd) continue;
        for (int y = 0; y < kh; y++) begin
          h = ph + y - pad_h;
          if (h < 0 || h >= hh) continue;
          for (int z = 0; z < kw; z++) begin
            w = col + z - pad_w;
            if (w < 0 || w >= ww) continue;
            sum = sum + 32'(voxel_mem[(d * MaxHeightDef + h) * MaxWidthDef + w])
                      * 32'(weight_mem[(x * MaxKernelDef + y) * MaxKernelDef + z]);
          end
        end
      end
      word = '{value: sum, col: col[PosWW-1:0], last: (col + 1 == ww), bad: 1'b0};
      conv_sums_q.push_back(word);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) begin
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
    end
  endtask

  // Follow every handshake; config writes only happen while nothing is in flight.
  always @(posedge clk_i or negedge rst_ni) begin
    conv_word_t want;
    if (!rst_ni) begin
      in_d = MaxDepthDef;
      in_h = MaxHeightDef;
      in_w = MaxWidthDef;
      k_d = 3;
      k_h = 3;
      k_w = 3;
      conv_sums_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_i)
          RegInDepth:   in_d = cfg_data_i & 7'h1F;
          RegInHeight:  in_h = cfg_data_i;
          RegInWidth:   in_w = cfg_data_i;
          RegKerDepth:  k_d = cfg_data_i & 7'h07;
          RegKerHeight: k_h = cfg_data_i & 7'h07;
          RegKerWidth:  k_w = cfg_data_i & 7'h07;
          default: ;
        endcase
      end
      if (push && !full) begin
        case (mode_i)
          ModeImage: begin
            if (pos_d_i < clamp_dim(in_d, MaxDepthDef) && pos_h_i < clamp_dim(in_h, MaxHeightDef)
                && pos_w_i < clamp_dim(in_w, MaxWidthDef)) begin
              voxel_mem[(pos_d_i * MaxHeightDef + pos_h_i) * MaxWidthDef + pos_w_i] = sample_i;
            end
          end
          ModeKernel: begin
            if (pos_d_i < clamp_dim(k_d, MaxKernelDef) && pos_h_i < clamp_dim(k_h, MaxKernelDef)
                && pos_w_i < clamp_dim(k_w, MaxKernelDef)) begin
              weight_mem[(pos_d_i * MaxKernelDef + pos_h_i) * MaxKernelDef + pos_w_i] = sample_i;
            end
          end
          ModeRow: predict_row(pos_d_i, pos_h_i);
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (conv_sums_q.size() == 0) begin
          note_mismatch("unexpected word", '0, out_value_i);
        end else begin
          want = conv_sums_q.pop_front();
          if (out_value_i !== want.value) note_mismatch("out_value", want.value, out_value_i);
          if (out_col_i !== want.col) note_mismatch("out_col", want.col, out_col_i);
          if (is_last_i !== want.last) note_mismatch("is_last", want.last, is_last_i);
          if (bad_request_i !== want.bad) note_mismatch("bad_request", want.bad, bad_request_i);
        end
      end
    end
    pending_o = conv_sums_q.size();
  end

  initial begin
    fail_cnt_o = 0;
    pending_o = 0;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the zero-padded 3D convolution unit.
// Drives config, voxel, weight and row request words, pops results; c3d_checker judges them.
// Depends on c3d_pkg, c3d_checker and conv3d_zero_padded_unit.
module tb_top;
  import c3d_pkg::*;

  localparam int CycleLimit = 3_000_000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0]          cfg_index_i;
  logic [CfgDataW-1:0]         cfg_data_i;
  logic                        push, full, empty, pop;
  logic [ModeW-1:0]            mode_i;
  logic [PosDW-1:0]            pos_d_i;
  logic [PosHW-1:0]            pos_h_i;
  logic [PosWW-1:0]            pos_w_i;
  logic signed [InSampleW-1:0] sample_i;
  logic signed [ValueW-1:0]    out_value_o;
  logic [PosWW-1:0]            out_col_o;
  logic                        is_last_o, bad_request_o;
  int                          fail_cnt, pending;
  int                          cycle_cnt;
  bit                          no_idle;
  bit                          hold_results;
  int unsigned                 size_reg [6];
  bit                          voxel_set [16384];
  bit                          weight_set [343];

  conv3d_zero_padded_unit u_top (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .push, .full, .mode_i, .pos_d_i, .pos_h_i, .pos_w_i, .sample_i,
    .empty, .pop, .out_value_o, .out_col_o, .is_last_o, .bad_request_o
  );

  c3d_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .push, .full, .mode_i, .pos_d_i, .pos_h_i, .pos_w_i, .sample_i,
    .empty, .pop, .out_value_i(out_value_o), .out_col_i(out_col_o),
    .is_last_i(is_last_o), .bad_request_i(bad_request_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clamped size of one register as the block uses it.
  function automatic int unsigned dim(input logic [CfgIdxW-1:0] idx);
    int unsigned hi;
    case (idx)
      RegInDepth:  hi = MaxDepthDef;
      RegInHeight: hi = MaxHeightDef;
      RegInWidth:  hi = MaxWidthDef;
      default:     hi = MaxKernelDef;
    endcase
    return (size_reg[idx] > hi) ? hi : size_reg[idx];
  endfunction

  // Offer one input word after a random gap and wait until it is taken.
  task automatic send_word(input logic [ModeW-1:0] m, input int unsigned d, input int unsigned h,
                           input int unsigned w, input logic [15:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= m;
    pos_d_i <= d[PosDW-1:0];
    pos_h_i <= h[PosHW-1:0];
    pos_w_i <= w[PosWW-1:0];
    sample_i <= s;
    do @(posedge clk_i); while (full);
    // Remember which store entries now hold data.
    if (m == ModeImage && d < dim(RegInDepth) && h < dim(RegInHeight)
        && w < dim(RegInWidth)) begin
      voxel_set[(d * 64 + h) * 64 + w] = 1'b1;
    end
    if (m == ModeKernel && d < dim(RegKerDepth) && h < dim(RegKerHeight)
        && w < dim(RegKerWidth)) begin
      weight_set[(d * 7 + h) * 7 + w] = 1'b1;
    end
  endtask

  // Wait until every expected word is out and loads have drained, then write a register.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegInDepth, RegKerDepth, RegKerHeight, RegKerWidth: begin
        size_reg[idx] = value & ((idx == RegInDepth) ? 32'h1F : 32'h07);
      end
      default: size_reg[idx] = value & 32'h7F;
    endcase
  endtask

  task automatic set_sizes(input int unsigned d, input int unsigned h, input int unsigned w,
                           input int unsigned kd, input int unsigned kh, input int unsigned kw);
    write_reg(RegInDepth, d);
    write_reg(RegInHeight, h);
    write_reg(RegInWidth, w);
    write_reg(RegKerDepth, kd);
    write_reg(RegKerHeight, kh);
    write_reg(RegKerWidth, kw);
  endtask

  // Fill every entry of the current volume and kernel that was never written, or every
  // entry when extreme is set, so no row ever reads an undefined value.
  task automatic fill_stores(input bit extreme);
    logic [15:0] s;
    for (int d = 0; d < dim(RegInDepth); d++)
      for (int h = 0; h < dim(RegInHeight); h++)
        for (int w = 0; w < dim(RegInWidth); w++)
          if (!voxel_set[(d * 64 + h) * 64 + w] || extreme) begin
            s = extreme ? 16'h8000 : 16'($urandom);
            send_word(ModeImage, d, h, w, s);
          end
    for (int d = 0; d < dim(RegKerDepth); d++)
      for (int h = 0; h < dim(RegKerHeight); h++)
        for (int w = 0; w < dim(RegKerWidth); w++)
          if (!weight_set[(d * 7 + h) * 7 + w] || extreme) begin
            s = extreme ? 16'h8000 : 16'($urandom);
            send_word(ModeKernel, d, h, w, s);
          end
  endtask

  // Random words: mostly valid row requests, some loads anywhere, bad rows and mode three.
  task automatic random_words(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (i % 16 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (pick < 55 && dim(RegInDepth) > 0 && dim(RegInHeight) > 0) begin
        send_word(ModeRow, $urandom_range(0, dim(RegInDepth) - 1),
                  $urandom_range(0, dim(RegInHeight) - 1),
                  $urandom_range(0, 63), 16'($urandom));
      end else if (pick < 70) begin
        send_word(ModeRow, $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 63), 16'($urandom));
      end else if (pick < 82) begin
        send_word(ModeImage, $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 63), 16'($urandom));
      end else if (pick < 94) begin
        send_word(ModeKernel, $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 63), 16'($urandom));
      end else begin
        send_word(ModeUnused, $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 63), 16'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: random pop gaps, plus one long hold-off when asked.
  initial begin
    int gap;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_results) begin
        pop <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_results = 1'b0;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    push = 1'b0;
    mode_i = ModeImage;
    pos_d_i = '0;
    pos_h_i = '0;
    pos_w_i = '0;
    sample_i = '0;
    no_idle = 1'b0;
    hold_results = 1'b0;
    size_reg = '{16, 64, 64, 3, 3, 3};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small volume, extreme samples, edges, bad rows, ignored words.
    set_sizes(2, 3, 5, 3, 3, 3);
    send_word(ModeImage, 0, 0, 0, 16'h7FFF);
    send_word(ModeImage, 1, 2, 4, 16'h8000);
    send_word(ModeKernel, 0, 0, 0, 16'h8000);
    send_word(ModeKernel, 2, 2, 2, 16'h7FFF);
    fill_stores(1'b0);
    send_word(ModeImage, 15, 63, 63, 16'hFFFF);
    send_word(ModeKernel, 3, 0, 0, 16'h1234);
    send_word(ModeUnused, 15, 63, 63, 16'hFFFF);
    send_word(ModeRow, 0, 0, 63, 16'h0000);
    send_word(ModeRow, 1, 2, 0, 16'h0000);
    send_word(ModeRow, 0, 1, 0, 16'h0000);
    send_word(ModeRow, 2, 0, 0, 16'h0000);
    send_word(ModeRow, 0, 63, 0, 16'h0000);
    send_word(ModeRow, 15, 63, 63, 16'hFFFF);

    // Widest row with the width register above its maximum, a seven-tap kernel along
    // columns and every product at its maximum, so sums wrap.
    set_sizes(1, 1, 127, 1, 1, 7);
    fill_stores(1'b1);
    send_word(ModeRow, 0, 0, 0, 16'h0000);
    random_words(2);

    // Deep and narrow, unit kernel; results held back so the input side stalls.
    set_sizes(8, 2, 2, 1, 1, 1);
    fill_stores(1'b0);
    hold_results = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 12; i++) send_word(ModeRow, i % 8, i % 2, 0, 16'h0000);
    no_idle = 1'b0;
    random_words(15);

    // Depth register above its maximum, even kernel sizes.
    set_sizes(31, 1, 1, 2, 2, 2);
    fill_stores(1'b0);
    random_words(15);

    // Empty kernel dimension gives zero sums.
    set_sizes(3, 3, 4, 2, 3, 0);
    fill_stores(1'b0);
    random_words(15);

    // Empty image dimensions make every row bad.
    set_sizes(0, 4, 0, 3, 3, 3);
    random_words(10);

    // One random small setting.
    set_sizes($urandom_range(1, 2), $urandom_range(1, 3), $urandom_range(1, 6),
              $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3));
    fill_stores(1'b0);
    random_words(20);

    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/c3d_pkg.sv
src/c3d_ram.sv
src/c3d_cmd_fifo.sv
src/c3d_front.sv
src/c3d_back.sv
src/conv3d_zero_padded_unit.sv
verif/c3d_checker.sv
verif/tb_top.sv
